/* hw/rtl/psbp_pkg.sv */
// Shared definitions for the path selector tag Bloom parser.
// Holds the parameter defaults, the parse snapshot record and the Bloom fold.
// No dependencies.
package psbp_pkg;

  localparam int TOKEN_MAX_DEF = 255;
  localparam int PATH_MAX_DEF  = 1024;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [31:0] TAG_HEAD  = 32'h7461673A;

  localparam logic [5:0] ID_HEX_CHARS  = 6'd32;
  localparam logic [5:0] ID_HALF_CHARS = 6'd16;
  localparam logic [5:0] ID_PREFIX_LEN = 6'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LOW_D = 8'h64;
  localparam logic [7:0] CH_LOW_I = 8'h69;

  typedef enum logic [1:0] {
    MODE_ID      = 2'd0,
    MODE_NAMED   = 2'd1,
    MODE_TAG     = 2'd2,
    MODE_INVALID = 2'd3
  } mode_e;

  typedef struct packed {
    logic        id_matched;
    logic        id_full;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [63:0] mask;
    logic        fin;
    logic [63:0] fin_hash;
    logic [9:0]  name_begin;
    logic [7:0]  name_len;
    logic [10:0] slice;
  } snap_t;

  function automatic logic [63:0] bloom(logic [63:0] h);
    logic [63:0] m;
    m = (64'd1 << h[5:0]) | (64'd1 << h[26:21]) | (64'd1 << h[47:42]);
    return m;
  endfunction

endpackage

/* hw/rtl/psbp_parser.sv */
// Input register and single-pass parse stage: id parser and token parser
// run side by side, a path snapshot is registered on the last request.
// Depends on psbp_pkg.
module psbp_parser import psbp_pkg::*; #(
  parameter int TOKEN_MAX = TOKEN_MAX_DEF,
  parameter int PATH_MAX  = PATH_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       in_stall_o,
  input  logic       snap_ready_i,
  output logic       snap_valid_o,
  output snap_t      snap_o
);

  localparam int POS_W = $clog2(PATH_MAX);
  localparam int TC_W  = $clog2(TOKEN_MAX + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PATH_MAX - 1);
  localparam logic [TC_W-1:0]  TOK_LAST = TC_W'(TOKEN_MAX);
  localparam logic [TC_W-1:0]  TOK_HEAD_LEN = TC_W'(4);

  typedef enum logic [2:0] {
    LEAD_FIRST = 3'b001,
    LEAD_RUN   = 3'b010,
    LEAD_END   = 3'b100
  } lead_e;

  typedef enum logic [2:0] {
    ID_MATCHING = 3'b001,
    ID_FAILED   = 3'b010,
    ID_MATCHED  = 3'b100
  } id_e;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    lead_e            lead;
    id_e              id_st;
    logic [5:0]       id_cnt;
    logic [63:0]      id_high;
    logic [63:0]      id_low;
    logic [1:0]       stops;
    logic [63:0]      hash_whole;
    logic [63:0]      hash_tail;
    logic [TC_W-1:0]  tok_cnt;
    logic [31:0]      tok_head;
    logic [POS_W-1:0] tok_begin;
    logic             tag_grp;
    logic [63:0]      mask;
    logic [POS_W-1:0] name_begin;
    logic [TC_W-1:0]  name_len;
    logic             stopped;
    logic [10:0]      slice;
    logic             fin;
    logic [63:0]      fin_hash;
  } state_t;

  function automatic state_t reset_state();
    state_t s;
    s            = '0;
    s.lead       = LEAD_FIRST;
    s.id_st      = ID_MATCHING;
    s.hash_whole = FNV_BASIS;
    s.hash_tail  = FNV_BASIS;
    return s;
  endfunction

  // FNV-1a 64 round; the prime is 2^40 + 0x1B3
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] c);
    logic [63:0] x;
    x = h ^ {56'd0, c};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = {1'b1, c[3:0] + 4'd9};
    end
    return d;
  endfunction

  function automatic logic [7:0] prefix_char(logic [5:0] n);
    logic [7:0] p;
    case (n)
      6'd0: p = CH_LOW_I;
      6'd1: p = CH_LOW_D;
      6'd2: p = CH_COLON;
      default: p = CH_NUL;
    endcase
    return p;
  endfunction

  function automatic state_t step(state_t s_in, logic [7:0] c);
    state_t      s;
    logic [4:0]  hd;
    logic        hi_half;
    logic        delim;
    logic [10:0] slice_mark;
    s          = s_in;
    hd         = hex_digit(c);
    hi_half    = 1'b0;
    delim      = (c == CH_SLASH) || (c == CH_PLUS) || (c == CH_HASH) || (c == CH_NUL);
    slice_mark = '0;
    if (s.lead != LEAD_END) begin
      if (s.pos < POS_LAST) begin
        s.pos = s.pos + 1'b1;
      end
      slice_mark = {1'b1, 10'(s.pos)};
      if (s.lead == LEAD_FIRST && c == CH_SLASH) begin
        s.lead      = LEAD_RUN;
        s.tok_begin = s.pos;
      end else begin
        s.lead = LEAD_RUN;
        case (s.id_st)
          ID_MATCHING: begin
            if (s.id_cnt < ID_PREFIX_LEN && c == prefix_char(s.id_cnt)) begin
              if (s.id_cnt == ID_PREFIX_LEN - 6'd1) begin
                s.id_st  = ID_MATCHED;
                s.id_cnt = '0;
              end else begin
                s.id_cnt = s.id_cnt + 6'd1;
              end
            end else begin
              s.id_st = ID_FAILED;
            end
          end
          ID_MATCHED: begin
            if (s.id_cnt < ID_HEX_CHARS) begin
              if (c != CH_NUL) begin
                hi_half = s.id_cnt < ID_HALF_CHARS;
                if (hi_half && !s.stops[0]) begin
                  if (!hd[4]) s.stops[0] = 1'b1;
                  else s.id_high = {s.id_high[59:0], hd[3:0]};
                end else if (!hi_half && !s.stops[1]) begin
                  if (!hd[4]) s.stops[1] = 1'b1;
                  else s.id_low = {s.id_low[59:0], hd[3:0]};
                end
                s.id_cnt = s.id_cnt + 6'd1;
              end
            end else if (s.id_cnt == ID_HEX_CHARS) begin
              if (c == CH_HASH) s.slice = slice_mark;
              s.id_cnt = s.id_cnt + 6'd1;
            end
          end
          default: ;
        endcase
        if (!s.stopped) begin
          if (delim) begin
            if (s.tok_cnt != '0) begin
              if (s.tok_cnt >= TOK_HEAD_LEN && s.tok_head == TAG_HEAD) begin
                s.tag_grp  = 1'b1;
                s.fin      = 1'b1;
                s.fin_hash = s.hash_tail;
              end else if (s.tag_grp) begin
                s.fin      = 1'b1;
                s.fin_hash = s.hash_whole;
              end else begin
                s.name_begin = s.tok_begin;
                s.name_len   = s.tok_cnt;
              end
            end
            if (c == CH_SLASH) s.tag_grp = 1'b0;
            s.tok_cnt    = '0;
            s.tok_head   = '0;
            s.hash_whole = FNV_BASIS;
            s.hash_tail  = FNV_BASIS;
            s.tok_begin  = s.pos;
            if (c == CH_HASH || c == CH_NUL) begin
              s.stopped = 1'b1;
              if (c == CH_HASH && s.id_st == ID_FAILED) s.slice = slice_mark;
            end
          end else if (s.tok_cnt < TOK_LAST) begin
            s.hash_whole = fnv_step(s.hash_whole, c);
            if (s.tok_cnt >= TOK_HEAD_LEN) s.hash_tail = fnv_step(s.hash_tail, c);
            else s.tok_head = {s.tok_head[23:0], c};
            s.tok_cnt = s.tok_cnt + 1'b1;
          end
        end
        if (c == CH_NUL) s.lead = LEAD_END;
      end
    end
    return s;
  endfunction

  logic       in_vld_q, in_vld_d;
  logic [7:0] ch_q;
  logic       last_q;
  logic       accept;
  logic       go;
  logic       snap_free;
  logic       snap_vld_q, snap_vld_d;
  snap_t      snap_q, snap_d;
  state_t     st_q, st_d, nxt;

  assign snap_free  = !snap_vld_q || snap_ready_i;
  assign go         = in_vld_q && (!last_q || snap_free);
  assign in_stall_o = in_vld_q && !go;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    nxt      = st_q;
    // fold the Bloom bits of the token closed in the previous cycle
    nxt.mask = st_q.mask | (st_q.fin ? bloom(st_q.fin_hash) : 64'd0);
    nxt.fin  = 1'b0;
    if (go) begin
      nxt = step(nxt, ch_q);
      if (last_q) nxt = step(nxt, CH_NUL);
    end
    st_d = (go && last_q) ? reset_state() : nxt;

    snap_d.id_matched = nxt.id_st == ID_MATCHED;
    snap_d.id_full    = nxt.id_cnt >= ID_HEX_CHARS;
    snap_d.id_high    = nxt.id_high;
    snap_d.id_low     = nxt.id_low;
    snap_d.mask       = nxt.mask;
    snap_d.fin        = nxt.fin;
    snap_d.fin_hash   = nxt.fin_hash;
    snap_d.name_begin = 10'(nxt.name_begin);
    snap_d.name_len   = 8'(nxt.name_len);
    snap_d.slice      = nxt.slice;

    if (go && last_q) snap_vld_d = 1'b1;
    else if (snap_ready_i) snap_vld_d = 1'b0;
    else snap_vld_d = snap_vld_q;

    if (accept) in_vld_d = 1'b1;
    else if (go) in_vld_d = 1'b0;
    else in_vld_d = in_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      snap_vld_q <= 1'b0;
      st_q       <= reset_state();
    end else begin
      in_vld_q   <= in_vld_d;
      snap_vld_q <= snap_vld_d;
      st_q       <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
    if (go && last_q) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_vld_q;
  assign snap_o       = snap_q;

  a_path_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && last_q |=> snap_vld_q && st_q.lead == LEAD_FIRST && st_q.pos == '0)
    else $error("parse state not restored after last request");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_vld_q && !snap_ready_i |=> snap_vld_q && $stable(snap_q))
    else $error("waiting snapshot changed");

  a_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.lead == LEAD_END |-> st_q.stopped)
    else $error("token parser still running after NUL");

  a_fin_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.fin |-> $past(go) && !$past(last_q))
    else $error("pending Bloom fold without a parsed request");

endmodule

/* hw/rtl/psbp_result.sv */
// Result register: folds the final Bloom bits, selects the mode and
// clears the unused fields of a path snapshot.
// Depends on psbp_pkg.
module psbp_result import psbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        snap_valid_i,
  input  snap_t       snap_i,
  output logic        snap_ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  mode_o,
  output logic [63:0] id_high_o,
  output logic [63:0] id_low_o,
  output logic [63:0] tag_mask_o,
  output logic [9:0]  name_start_o,
  output logic [7:0]  name_len_o,
  output logic        slice_present_o,
  output logic [9:0]  slice_pos_o
);

  logic        out_vld_q, out_vld_d;
  logic        load;
  logic [63:0] mask_full;
  mode_e       mode_q, mode_d;
  logic [63:0] id_high_q, id_high_d, id_low_q, id_low_d, mask_q, mask_d;
  logic [9:0]  nstart_q, nstart_d, spos_q, spos_d;
  logic [7:0]  nlen_q, nlen_d;
  logic        sp_q, sp_d;

  assign snap_ready_o = !out_vld_q || !out_stall_i;
  assign load         = snap_valid_i && snap_ready_o;

  always_comb begin
    mask_full = snap_i.mask | (snap_i.fin ? bloom(snap_i.fin_hash) : 64'd0);
    mode_d    = MODE_INVALID;
    id_high_d = '0;
    id_low_d  = '0;
    mask_d    = '0;
    nstart_d  = '0;
    nlen_d    = '0;
    sp_d      = 1'b0;
    if (snap_i.id_matched) begin
      if (snap_i.id_full) begin
        mode_d    = MODE_ID;
        id_high_d = snap_i.id_high;
        id_low_d  = snap_i.id_low;
        sp_d      = snap_i.slice[10];
      end
    end else if (snap_i.name_len != '0) begin
      mode_d   = MODE_NAMED;
      mask_d   = mask_full;
      nstart_d = snap_i.name_begin;
      nlen_d   = snap_i.name_len;
      sp_d     = snap_i.slice[10];
    end else if (mask_full != '0) begin
      mode_d = MODE_TAG;
      mask_d = mask_full;
      sp_d   = snap_i.slice[10];
    end
    spos_d = sp_d ? snap_i.slice[9:0] : 10'd0;

    if (load) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q    <= mode_d;
      id_high_q <= id_high_d;
      id_low_q  <= id_low_d;
      mask_q    <= mask_d;
      nstart_q  <= nstart_d;
      nlen_q    <= nlen_d;
      sp_q      <= sp_d;
      spos_q    <= spos_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign mode_o          = mode_q;
  assign id_high_o       = id_high_q;
  assign id_low_o        = id_low_q;
  assign tag_mask_o      = mask_q;
  assign name_start_o    = nstart_q;
  assign name_len_o      = nlen_q;
  assign slice_present_o = sp_q;
  assign slice_pos_o     = spos_q;

  a_invalid_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && mode_q == MODE_INVALID |->
      id_high_q == '0 && id_low_q == '0 && mask_q == '0 && nlen_q == '0 && !sp_q)
    else $error("invalid result carries data");

  a_id_only_mode0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && mode_q != MODE_ID |-> id_high_q == '0 && id_low_q == '0)
    else $error("identifier outside id mode");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(snap_valid_i))
    else $error("result without a snapshot");

endmodule

/* hw/rtl/path_selector_tag_bloom_parser.sv */
// A last request is parsed into the snapshot register, then into the result register.
// Throughput: one character per cycle, set by the parse stage with its FNV-1a shift-add round
// between the input and snapshot registers; a last request stalls while a snapshot waits.
// Reset: asynchronous, active low; clears all parse state, which also returns to its
// reset values after every path.
// Depends on psbp_pkg, psbp_parser and psbp_result.
module path_selector_tag_bloom_parser import psbp_pkg::*; #(
  parameter int TOKEN_MAX = TOKEN_MAX_DEF,
  parameter int PATH_MAX  = PATH_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  mode_o,
  output logic [63:0] id_high_o,
  output logic [63:0] id_low_o,
  output logic [63:0] tag_mask_o,
  output logic [9:0]  name_start_o,
  output logic [7:0]  name_len_o,
  output logic        slice_present_o,
  output logic [9:0]  slice_pos_o
);

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  psbp_parser #(
    .TOKEN_MAX(TOKEN_MAX),
    .PATH_MAX (PATH_MAX)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .snap_ready_i(snap_ready),
    .snap_valid_o(snap_valid),
    .snap_o      (snap)
  );

  psbp_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_valid_i   (snap_valid),
    .snap_i         (snap),
    .snap_ready_o   (snap_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mode_o         (mode_o),
    .id_high_o      (id_high_o),
    .id_low_o       (id_low_o),
    .tag_mask_o     (tag_mask_o),
    .name_start_o   (name_start_o),
    .name_len_o     (name_len_o),
    .slice_present_o(slice_present_o),
    .slice_pos_o    (slice_pos_o)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for path_selector_tag_bloom_parser: streams paths one character
// per request and predicts each path's result in-line. Depends on psbp_pkg and the block.
module tb import psbp_pkg::*;;

  typedef enum logic [1:0] {FIRST_CHAR, IN_PATH, PATH_ENDED} lead_e;
  typedef enum logic [1:0] {PFX_MATCHING, PFX_FAILED, PFX_MATCHED} prefix_e;

  typedef logic [7:0] path_t[$];

  typedef struct {
    mode_e       mode;
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic [63:0] mask;
    logic [9:0]  name_at;
    logic [7:0]  name_len;
    logic        slice_on;
    logic [9:0]  slice_at;
  } parse_rec_t;

  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
  localparam int unsigned POS_TOP = PATH_MAX_DEF - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam string HEX_SET = "0123456789abcdefABCDEF";
  localparam string NOISE_SET = "/+#:idtag0a";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i = 8'h00;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  mode_o;
  logic [63:0] id_high_o;
  logic [63:0] id_low_o;
  logic [63:0] tag_mask_o;
  logic [9:0]  name_start_o;
  logic [7:0]  name_len_o;
  logic        slice_present_o;
  logic [9:0]  slice_pos_o;

  path_selector_tag_bloom_parser DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .ch_i, .last_i,
    .out_valid_o, .out_stall_i, .mode_o, .id_high_o, .id_low_o, .tag_mask_o,
    .name_start_o, .name_len_o, .slice_present_o, .slice_pos_o
  );

  parse_rec_t pending_parses[$];
  int errors = 0;
  int results_checked = 0;
  int sent_chars = 0;
  int paths_sent = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  int unsigned cur_pos;
  lead_e       lead_st;
  prefix_e     pfx_st;
  int unsigned id_cnt;
  logic [63:0] id_hi_acc;
  logic [63:0] id_lo_acc;
  logic [1:0]  hex_halt;
  logic [63:0] fnv_all;
  logic [63:0] fnv_tail;
  int unsigned tok_len;
  logic [31:0] tok_head;
  int unsigned tok_start;
  logic        in_group;
  logic [63:0] bloom_acc;
  int unsigned file_start;
  int unsigned file_len;
  logic        tok_done;
  logic        slice_on;
  logic [9:0]  slice_at;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] fold_mask(input logic [63:0] h);
    logic [63:0] m;
    logic [5:0]  b;
    m = '0;
    for (int k = 0; k < 3; k++) begin
      b = 6'(h >> (21 * k));
      m[b] = 1'b1;
    end
    return m;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  function automatic void restart_token(input int unsigned start);
    tok_len = 0;
    tok_head = '0;
    fnv_all = FNV_BASIS;
    fnv_tail = FNV_BASIS;
    tok_start = start;
  endfunction

  function automatic void clear_parse();
    cur_pos = 0;
    lead_st = FIRST_CHAR;
    pfx_st = PFX_MATCHING;
    id_cnt = 0;
    id_hi_acc = '0;
    id_lo_acc = '0;
    hex_halt = '0;
    restart_token(0);
    in_group = 1'b0;
    bloom_acc = '0;
    file_start = 0;
    file_len = 0;
    tok_done = 1'b0;
    slice_on = 1'b0;
    slice_at = '0;
  endfunction

  function automatic void id_step(input logic [7:0] c, input int unsigned nxt);
    int d;
    logic [1:0] half;
    logic [7:0] want;
    case (pfx_st)
      PFX_MATCHING: begin
        want = (id_cnt == 0) ? CH_LOW_I : (id_cnt == 1) ? CH_LOW_D : CH_COLON;
        if (id_cnt < ID_PREFIX_LEN && c == want) begin
          id_cnt++;
          if (id_cnt == ID_PREFIX_LEN) begin
            pfx_st = PFX_MATCHED;
            id_cnt = 0;
          end
        end else begin
          pfx_st = PFX_FAILED;
        end
      end
      PFX_MATCHED: begin
        if (id_cnt < ID_HEX_CHARS) begin
          if (c != CH_NUL) begin
            half = (id_cnt < ID_HALF_CHARS) ? 2'b01 : 2'b10;
            if ((hex_halt & half) == 2'b00) begin
              d = hex_digit(c);
              if (d < 0) hex_halt |= half;
              else if (half == 2'b01) id_hi_acc = {id_hi_acc[59:0], d[3:0]};
              else id_lo_acc = {id_lo_acc[59:0], d[3:0]};
            end
            id_cnt++;
          end
        end else if (id_cnt == ID_HEX_CHARS) begin
          if (c == CH_HASH) begin
            slice_on = 1'b1;
            slice_at = nxt[9:0];
          end
          id_cnt++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void tok_step(input logic [7:0] c, input int unsigned nxt);
    if (tok_done) return;
    if (c == CH_SLASH || c == CH_PLUS || c == CH_HASH || c == CH_NUL) begin
      if (tok_len > 0) begin
        if (tok_len >= 4 && tok_head == TAG_HEAD) begin
          in_group = 1'b1;
          bloom_acc |= fold_mask(fnv_tail);
        end else if (in_group) begin
          bloom_acc |= fold_mask(fnv_all);
        end else begin
          file_start = tok_start;
          file_len = tok_len;
        end
      end
      if (c == CH_SLASH) in_group = 1'b0;
      restart_token(nxt);
      if (c == CH_HASH || c == CH_NUL) begin
        tok_done = 1'b1;
        if (c == CH_HASH && pfx_st == PFX_FAILED) begin
          slice_on = 1'b1;
          slice_at = nxt[9:0];
        end
      end
    end else if (tok_len < TOKEN_MAX_DEF) begin
      fnv_all = (fnv_all ^ {56'd0, c}) * FNV_PRIME;
      if (tok_len >= 4) fnv_tail = (fnv_tail ^ {56'd0, c}) * FNV_PRIME;
      else tok_head = {tok_head[23:0], c};
      tok_len++;
    end
  endfunction

  function automatic void take_char(input logic [7:0] c);
    if (lead_st == PATH_ENDED) return;
    if (cur_pos < POS_TOP) cur_pos++;
    if (lead_st == FIRST_CHAR) begin
      lead_st = IN_PATH;
      if (c == CH_SLASH) begin
        tok_start = cur_pos;
        return;
      end
    end
    id_step(c, cur_pos);
    tok_step(c, cur_pos);
    if (c == CH_NUL) lead_st = PATH_ENDED;
  endfunction

  function automatic parse_rec_t close_path();
    parse_rec_t r;
    r.mode = MODE_INVALID;
    r.id_hi = '0;
    r.id_lo = '0;
    r.mask = '0;
    r.name_at = '0;
    r.name_len = '0;
    r.slice_on = 1'b0;
    r.slice_at = '0;
    take_char(CH_NUL);
    if (pfx_st == PFX_MATCHED) begin
      if (id_cnt >= ID_HEX_CHARS) begin
        r.mode = MODE_ID;
        r.id_hi = id_hi_acc;
        r.id_lo = id_lo_acc;
        r.slice_on = slice_on;
      end
    end else if (file_len > 0) begin
      r.mode = MODE_NAMED;
      r.mask = bloom_acc;
      r.name_at = file_start[9:0];
      r.name_len = file_len[7:0];
      r.slice_on = slice_on;
    end else if (bloom_acc != '0) begin
      r.mode = MODE_TAG;
      r.mask = bloom_acc;
      r.slice_on = slice_on;
    end
    if (r.slice_on) r.slice_at = slice_at;
    clear_parse();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result();
    parse_rec_t want;
    if (pending_parses.size() == 0) begin
      report_mismatch($sformatf("result with no path pending, mode %0d", mode_o));
      return;
    end
    want = pending_parses.pop_front();
    check_field("mode", mode_o, want.mode);
    check_field("id_high", id_high_o, want.id_hi);
    check_field("id_low", id_low_o, want.id_lo);
    check_field("tag_mask", tag_mask_o, want.mask);
    check_field("name_start", name_start_o, want.name_at);
    check_field("name_len", name_len_o, want.name_len);
    check_field("slice_present", slice_present_o, want.slice_on);
    check_field("slice_pos", slice_pos_o, want.slice_at);
    results_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic path_t str_path(input string s);
    path_t p;
    for (int i = 0; i < s.len(); i++) p.push_back(s[i]);
    return p;
  endfunction

  function automatic path_t word(input int n);
    path_t p;
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(33, 126));
      if (c == CH_SLASH || c == CH_PLUS || c == CH_HASH) c = "q";
      p.push_back(c);
    end
    return p;
  endfunction

  function automatic path_t make_id_path();
    path_t p;
    int n;
    if ($urandom_range(1) == 1) p.push_back(CH_SLASH);
    p = {p, str_path("id:")};
    n = ($urandom_range(7) == 0) ? $urandom_range(0, 31) : 32;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) p.push_back(8'($urandom_range(1, 255)));
      else p.push_back(HEX_SET[$urandom_range(21)]);
    end
    case ($urandom_range(3))
      0: p = {p, CH_HASH, word($urandom_range(0, 6))};
      1: p = {p, CH_NUL, word($urandom_range(0, 4))};
      default: ;
    endcase
    return p;
  endfunction

  function automatic path_t make_tag_path();
    path_t p;
    int ntok;
    logic tags_only;
    if ($urandom_range(1) == 1) p.push_back(CH_SLASH);
    ntok = $urandom_range(1, 6);
    tags_only = ($urandom_range(3) == 0);
    for (int i = 0; i < ntok; i++) begin
      if (i > 0) p.push_back(($urandom_range(2) == 0) ? CH_SLASH : CH_PLUS);
      if (tags_only || $urandom_range(2) == 0) p = {p, str_path("tag:")};
      p = {p, word($urandom_range(0, 7))};
    end
    case ($urandom_range(5))
      0, 1: p = {p, CH_HASH, word($urandom_range(0, 5))};
      2: p = {p, CH_NUL, word($urandom_range(0, 3))};
      default: ;
    endcase
    return p;
  endfunction

  function automatic path_t make_noise_path();
    path_t p;
    int n;
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: p.push_back(8'($urandom_range(0, 255)));
        1: p.push_back(NOISE_SET[$urandom_range(NOISE_SET.len() - 1)]);
        default: p.push_back(8'($urandom_range(32, 126)));
      endcase
    end
    return p;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    last_i <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    take_char(c);
    if (l) pending_parses.push_back(close_path());
    sent_chars++;
  endtask

  task automatic send_path(input path_t p);
    if (p.size() == 0) p.push_back(CH_NUL);
    for (int i = 0; i < p.size(); i++) send_char(p[i], i == p.size() - 1);
    paths_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    string cases[$];
    cases = '{
      "/id:0123456789abcdefFEDCBA9876543210#5",
      "id:ffffffffffffffffFFFFFFFFFFFFFFFF",
      "id:12g456789abcdef00123x56789abcdef",
      "id:0123",
      "id:0123456789abcdef0123456789abcdef+x",
      "idx/file",
      "i",
      "tag:red+tag:blue",
      "tag:",
      "/docs/tag:a+b/report.txt#sl",
      "a/tag:x+y/#p",
      "#abc",
      "/",
      "//x+b+c",
      "tag:x/plain"
    };
    foreach (cases[i]) send_path(str_path(cases[i]));
    send_path('{CH_NUL});
    send_path({str_path("abc"), CH_NUL, str_path("zz")});
    send_path('{8'hFF, 8'h80, 8'h7F, 8'h01});
    send_path({str_path("/id:0123"), CH_NUL, str_path("4567")});
    send_path({str_path("name"), CH_NUL});
  endtask

  task automatic test_long_paths();
    path_t p;
    p = {str_path("tag:"), word(260), CH_PLUS, word(258), CH_SLASH, word(240), CH_SLASH,
         word(262), CH_HASH, word(2)};
    send_path(p);
  endtask

  task automatic test_id_selector(input int budget);
    int start;
    start = sent_chars;
    while (sent_chars - start < budget) send_path(make_id_path());
  endtask

  task automatic test_tag_groups(input int budget);
    int start;
    start = sent_chars;
    while (sent_chars - start < budget) send_path(make_tag_path());
  endtask

  task automatic test_noise(input int budget);
    int start;
    start = sent_chars;
    while (sent_chars - start < budget) send_path(make_noise_path());
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    for (int i = 0; i < 6; i++) send_path(($urandom_range(1) == 1) ? make_tag_path() : make_noise_path());
    wait_drained();
  endtask

  initial begin
    clear_parse();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 10;
    recv_stall_pct = 53;
    test_directed();
    test_long_paths();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 53 : 0;
      recv_stall_pct = (ph == 0) ? 53 : (ph == 1) ? 10 : 0;
      test_id_selector(50);
      test_tag_groups(40);
      test_noise(16);
    end
    test_backpressure();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("summary: %0d paths in %0d characters, %0d results compared",
             paths_sent, sent_chars, results_checked);
    $display("summary: id selectors, tag groups, long tokens and paths, noise, output hold-off");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
